// ===== rtl/feedback_ring_modulator_top_macros.svh =====
// Assertion macros for the feedback ring modulator checker.
// Used by frm_check; no other dependencies.
`ifndef FEEDBACK_RING_MODULATOR_TOP_MACROS_SVH
`define FEEDBACK_RING_MODULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frm check failed");

// Next-cycle implication, disabled while in reset.
`define FRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frm check failed");

`endif

// ===== rtl/frm_pkg.sv =====
// Shared constants and types for the feedback ring modulator.
// No dependencies; used by frm_if, frm_gain, frm_lane and the top level.
package frm_pkg;

	localparam int DEF_SINE_TABLE_DEPTH = 1024;
	localparam int DEF_SAMPLE_BITS      = 24;
	localparam int CFG_INDEX_W          = 8;
	localparam int CFG_DATA_W           = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP      = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DC_OFFSET       = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_DEPTH  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE_SCALE = 8'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WRAP_MIX        = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX         = 8'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_HARDCLIP_MIX    = 8'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECLIP_GAIN    = 8'd7;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [31:0]        phase_step;
		logic signed [15:0] dc_offset;
		logic signed [15:0] feedback_depth;
		logic signed [31:0] amplitude_scale;
		logic [15:0]        wrap_mix;
		logic [15:0]        wet_mix;
		logic [15:0]        hardclip_mix;
		logic [15:0]        preclip_gain;
	} cfg_t;

endpackage

// ===== rtl/frm_if.sv =====
// Stream and configuration interfaces of the feedback ring modulator.
// Depends on frm_pkg for the configuration port widths.
interface frm_in_if #(parameter int SB = 24);
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] left_sample;
	logic signed [SB-1:0] right_sample;
	modport source (output valid, left_sample, right_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface frm_out_if #(parameter int SB = 24);
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] left_result;
	logic signed [SB-1:0] right_result;
	modport source (output valid, left_result, right_result, input ready);
	modport sink   (input valid, left_result, right_result, output ready);
endinterface

interface frm_cfg_if import frm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/frm_gain.sv =====
// Carrier phase, feedback phase modulation, quarter-wave sine and gain shaping.
// Seven-stage pipeline, at most one multiply per stage. Depends on frm_pkg.
module frm_gain import frm_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        start,
	input  logic signed [SAMPLE_BITS:0] fb,
	output logic signed [63-SAMPLE_BITS:0] gain,
	output logic                        done
);

	localparam int D     = SINE_TABLE_DEPTH;
	localparam int SB    = SAMPLE_BITS;
	localparam int GW    = 64 - SB;
	localparam int IW    = $clog2(D + 1);
	localparam int PW    = 31 + IW;
	localparam int PRW   = SB + 17;
	localparam int FB_SH = (SB >= 21) ? (SB - 21) : (21 - SB);
	localparam logic signed [47:0] ONE_Q23 = 48'sd8388608;
	localparam logic signed [50:0] LIM_HI  = 51'sd1 <<< (62 - SB);
	localparam logic signed [50:0] LIM_LO  = -LIM_HI;

	function automatic logic [D:0][23:0] build_rom();
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [D:0][23:0]   r;
		for (int i = 0; i <= D; i++) begin
			x    = (64'(i) * PI_HALF_Q30) / D;
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed(x);
			for (int k = 1; k <= 8; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) sum = sum - $signed(term);
				else sum = sum + $signed(term);
			end
			if (sum < 0) sum = 0;
			sum = (sum + 64) >>> 7;
			if (sum > 64'sd8388608) sum = 64'sd8388608;
			r[i] = sum[23:0];
		end
		return r;
	endfunction

	localparam logic [D:0][23:0] ROM = build_rom();

	logic [31:0]            phase_q;
	logic [6:0]             vld_q;
	logic signed [PRW-1:0]  prod_s1;
	logic [IW-1:0]          idx_s2;
	logic [29:0]            fr_s2;
	logic [1:0]             quad_s2, quad_s3;
	logic [23:0]            a_s3;
	logic signed [55:0]     pi_s3;
	logic signed [59:0]     m_s4;
	logic signed [46:0]     g2_s5;
	logic signed [64:0]     p_s6;
	logic signed [GW-1:0]   gain_s7;

	// stage 2 logic
	logic signed [63:0] prod64;
	logic [31:0]        fbp, theta;
	logic [30:0]        f;
	logic [PW-1:0]      pos;
	// stage 3 logic
	logic [IW-1:0]      idx_n;
	logic [23:0]        rom_a, rom_b;
	logic signed [24:0] diff;
	// stage 4 logic
	logic signed [26:0] v;
	logic signed [27:0] sv;
	// stage 5 logic
	logic signed [43:0] g;
	logic signed [37:0] w;
	// stage 6/7 logic
	logic signed [47:0] d;
	logic signed [50:0] t;

	always_comb begin
		prod64 = 64'(prod_s1);
		if (SB >= 21) fbp = 32'(unsigned'(prod64) >> FB_SH);
		else fbp = 32'(unsigned'(prod64) << FB_SH);
		theta = phase_q + fbp;
		f     = {1'b0, theta[29:0]};
		if (theta[30]) f = 31'h4000_0000 - f;
		pos   = PW'(f) * PW'(D);
	end

	always_comb begin
		idx_n = idx_s2 + IW'(1);
		rom_a = ROM[idx_s2];
		rom_b = (32'(idx_s2) < D) ? ROM[idx_n] : rom_a;
		diff  = $signed({1'b0, rom_b}) - $signed({1'b0, rom_a});
	end

	always_comb begin
		v = $signed({3'b0, a_s3}) + 27'(pi_s3 >>> 30);
		if (quad_s3[1]) v = -v;
		sv = 28'(v) + 28'(cfg.dc_offset) * 28'sd512;
		g  = 44'(m_s4 >>> 16);
		w  = $signed({1'b0, cfg.wrap_mix}) * 21'(g >>> 23);
		d  = 48'(g2_s5) - ONE_Q23;
		t  = 51'(ONE_Q23) + 51'(p_s6 >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			vld_q   <= '0;
		end else begin
			vld_q <= {vld_q[5:0], start};
			if (start) phase_q <= phase_q + cfg.phase_step;
		end
	end

	always_ff @(posedge clk) begin
		if (start) prod_s1 <= PRW'(cfg.feedback_depth) * PRW'(fb);
		if (vld_q[0]) begin
			idx_s2  <= (pos[PW-1:30] > (PW-30)'(D)) ? IW'(D) : IW'(pos[PW-1:30]);
			fr_s2   <= pos[29:0];
			quad_s2 <= theta[31:30];
		end
		if (vld_q[1]) begin
			a_s3    <= rom_a;
			pi_s3   <= 56'(diff) * $signed({26'b0, fr_s2});
			quad_s3 <= quad_s2;
		end
		if (vld_q[2]) m_s4 <= 60'(sv) * 60'(cfg.amplitude_scale);
		if (vld_q[3]) g2_s5 <= 47'(g) - (47'(w) <<< 8);
		if (vld_q[4]) p_s6 <= $signed({49'b0, cfg.wet_mix}) * 65'(d);
		if (vld_q[5]) begin
			if (t > LIM_HI) gain_s7 <= GW'(LIM_HI);
			else if (t < LIM_LO) gain_s7 <= GW'(LIM_LO);
			else gain_s7 <= GW'(t);
		end
	end

	assign gain = gain_s7;
	assign done = vld_q[6];

endmodule

// ===== rtl/frm_lane.sv =====
// One channel lane: gain multiply, hard-clip blend and output saturation.
// Three stages; two instances run side by side. Depends on frm_pkg.
module frm_lane import frm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          start,
	input  logic signed [63-SAMPLE_BITS:0] gain,
	input  logic signed [SAMPLE_BITS-1:0] x,
	output logic signed [SAMPLE_BITS-1:0] y,
	output logic                          done
);

	localparam int SB = SAMPLE_BITS;
	localparam logic signed [49:0] UNIT   = 50'sd1 <<< (SB - 1);
	localparam logic signed [59:0] Y_HI   = (60'sd1 <<< (SB - 1)) - 60'sd1;
	localparam logic signed [59:0] Y_LO   = -(60'sd1 <<< (SB - 1));

	logic [2:0]           vld_q;
	logic signed [40:0]   s_s1, s_s2;
	logic signed [41:0]   d_s2;
	logic signed [SB-1:0] y_s3;

	logic signed [63:0] gx;
	logic signed [57:0] pc;
	logic signed [49:0] hs, h;
	logic signed [58:0] hq;
	logic signed [59:0] yy;

	always_comb begin
		gx = 64'(gain) * 64'(x);
		pc = $signed({42'b0, cfg.preclip_gain}) * 58'(s_s1);
		hs = 50'(pc >>> 8);
		if (hs > UNIT) h = UNIT;
		else if (hs < -UNIT) h = -UNIT;
		else h = hs;
		hq = $signed({43'b0, cfg.hardclip_mix}) * 59'(d_s2);
		yy = 60'(s_s2) + 60'(hq >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[1:0], start};
	end

	always_ff @(posedge clk) begin
		if (start) s_s1 <= 41'(gx >>> 23);
		if (vld_q[0]) begin
			s_s2 <= s_s1;
			d_s2 <= 42'(h) - 42'(s_s1);
		end
		if (vld_q[1]) begin
			if (yy > Y_HI) y_s3 <= SB'(Y_HI);
			else if (yy < Y_LO) y_s3 <= SB'(Y_LO);
			else y_s3 <= SB'(yy);
		end
	end

	assign y    = y_s3;
	assign done = vld_q[2];

endmodule

// ===== rtl/feedback_ring_modulator_top.sv =====
// Feedback ring modulator. One stereo word in, one stereo word out. An accepted
// word runs through the gain pipeline (phase, sine lookup with interpolation,
// DC, scale, wrap, wet blend) and then through the two channel lanes, whose
// results are registered into the result word. The next word depends on the
// previous result (feedback), so one word is in flight at a time: samples.ready
// returns the cycle after the result word is taken. Configuration writes are
// always taken (cfg.ready is tied high) and must only happen while idle.
module feedback_ring_modulator_top import frm_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	frm_in_if.sink   samples,
	frm_out_if.source results,
	frm_cfg_if.sink  cfg
);

	localparam int SB = SAMPLE_BITS;
	localparam int GW = 64 - SB;

	// configuration registers
	cfg_t cfg_q;

	// control
	logic busy_q;
	logic res_vld_q;
	logic in_acc;
	logic gain_done, lane_done_l, lane_done_r;

	// payload and feedback state
	logic signed [SB-1:0] xl_q, xr_q;
	logic signed [SB-1:0] last_l_q, last_r_q;
	logic signed [SB-1:0] yl, yr;
	logic signed [SB-1:0] res_l_q, res_r_q;
	logic signed [SB:0]   fb;
	logic signed [GW-1:0] gain;

	assign in_acc        = samples.valid && samples.ready;
	assign samples.ready = !busy_q;
	assign cfg.ready     = 1'b1;
	assign fb            = (SB+1)'(last_l_q) + (SB+1)'(last_r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step      <= '0;
			cfg_q.dc_offset       <= '0;
			cfg_q.feedback_depth  <= '0;
			cfg_q.amplitude_scale <= 32'sd65536;
			cfg_q.wrap_mix        <= '0;
			cfg_q.wet_mix         <= 16'd32768;
			cfg_q.hardclip_mix    <= '0;
			cfg_q.preclip_gain    <= 16'd256;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PHASE_STEP:      cfg_q.phase_step      <= cfg.data;
				REG_DC_OFFSET:       cfg_q.dc_offset       <= cfg.data[15:0];
				REG_FEEDBACK_DEPTH:  cfg_q.feedback_depth  <= cfg.data[15:0];
				REG_AMPLITUDE_SCALE: cfg_q.amplitude_scale <= cfg.data;
				REG_WRAP_MIX:        cfg_q.wrap_mix        <= cfg.data[15:0];
				REG_WET_MIX:         cfg_q.wet_mix         <= cfg.data[15:0];
				REG_HARDCLIP_MIX:    cfg_q.hardclip_mix    <= cfg.data[15:0];
				REG_PRECLIP_GAIN:    cfg_q.preclip_gain    <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// busy from acceptance until the result word leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			res_vld_q <= 1'b0;
			last_l_q  <= '0;
			last_r_q  <= '0;
		end else begin
			if (in_acc) busy_q <= 1'b1;
			else if (results.valid && results.ready) busy_q <= 1'b0;
			if (lane_done_l) res_vld_q <= 1'b1;
			else if (results.ready) res_vld_q <= 1'b0;
			if (lane_done_l) begin
				last_l_q <= yl;
				last_r_q <= yr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			xl_q <= samples.left_sample;
			xr_q <= samples.right_sample;
		end
		if (lane_done_l) begin
			res_l_q <= yl;
			res_r_q <= yr;
		end
	end

	frm_gain #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_gain (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(in_acc), .fb(fb),
		.gain(gain), .done(gain_done)
	);

	// left and right lanes share the gain
	frm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(gain_done), .gain(gain),
		.x(xl_q), .y(yl), .done(lane_done_l)
	);

	frm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(gain_done), .gain(gain),
		.x(xr_q), .y(yr), .done(lane_done_r)
	);

	// merge: both lanes finish together; the result word carries both
	assign results.valid        = res_vld_q && !(lane_done_l ^ lane_done_r) || res_vld_q;
	assign results.left_result  = res_l_q;
	assign results.right_result = res_r_q;

endmodule

// ===== rtl/frm_check.sv =====
// Port-level checker for the feedback ring modulator, bound to the top level.
// Depends on feedback_ring_modulator_top_macros.svh.
`include "feedback_ring_modulator_top_macros.svh"

module frm_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	`FRM_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)
	`FRM_ASSERT_NOW(a_no_take_with_result, clk, arst_n, out_valid, !in_ready)
	`FRM_ASSERT_NEXT(a_ready_after_result, clk, arst_n, out_valid && out_ready, in_ready)
	`FRM_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule

bind feedback_ring_modulator_top frm_check u_frm_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samples.valid),
	.in_ready(samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready)
);
